// ===== rtl/core/bdf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, coefficient tables and register codes of the BDF history unit.
package bdf_pkg;

  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int ORD_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;
  localparam int COEF_W    = 19;
  localparam int PROD_W    = DATA_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_W     = SUM_W - FRAC_W;
  localparam int PH_W      = RND_W - DATA_W + DATA_W + 1;
  localparam int SCL_W     = PH_W + DATA_W;
  localparam int SAT_W     = SCL_W - FRAC_W;
  localparam int TAB_ORDERS = 3;

  localparam int RND_POS = 32768;
  localparam int RND_NEG = 32767;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 2'd2;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t ALPHA_TAB [TAB_ORDERS][TAB_ORDERS] = '{
    '{19'sd65536,  19'sd0,      19'sd0},
    '{19'sd131072, -19'sd32768, 19'sd0},
    '{19'sd196608, -19'sd98304, 19'sd21845}
  };

  localparam coef_t BETA_TAB [TAB_ORDERS][TAB_ORDERS] = '{
    '{19'sd65536,  19'sd0,       19'sd0},
    '{19'sd131072, -19'sd65536,  19'sd0},
    '{19'sd196608, -19'sd196608, 19'sd65536}
  };

  typedef struct packed {
    logic [IDX_W-1:0]         elem_index;
    logic signed [DATA_W-1:0] sample;
    logic                     init;
    logic                     last_in;
  } elem_t;

  typedef struct packed {
    logic [IDX_W-1:0]         out_index;
    logic signed [DATA_W-1:0] deriv_term;
    logic signed [DATA_W-1:0] extrapolated;
    logic                     last_out;
  } result_t;

endpackage

// ===== rtl/core/bdf_history_derivative_extrapolator.sv =====
`timescale 1ns / 1ps
// Top level of the BDF history unit: history memory, coefficient sums, scaling.
//
// Accepts one element per cycle and presents its result through eight register
// stages (s1 to s7 and the result register); a stall on the result channel
// holds the whole pipeline and stalls the element channel in the same cycle.
// Each element index owns one history row of MAX_ORDER Q16.16 values in a
// memory with one registered read port and one write port; the row is read,
// updated and written back in consecutive stages, and a row still in flight is
// forwarded, so repeated indexes stream at full rate. The history holds
// whatever was last written and is undefined for an index until an element
// with init set has filled it. Configuration writes also apply to elements
// already in the pipeline and belong in idle periods.
module bdf_history_derivative_extrapolator #(
  parameter int VECTOR_LEN = 1024,
  parameter int MAX_ORDER  = 3
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              elem_valid,
  output logic                              elem_stall,
  input  bdf_pkg::elem_t                    elem,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bdf_pkg::result_t                  result,
  input  logic                              cfg_write,
  input  logic [bdf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bdf_pkg::DATA_W-1:0]        cfg_data
);
  import bdf_pkg::*;

  localparam int POS_W      = (VECTOR_LEN > 1) ? $clog2(VECTOR_LEN) : 1;
  localparam int RECIP_SH   = 21;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int RECIP      = ((1 << RECIP_SH) + VECTOR_LEN - 1) / VECTOR_LEN;
  localparam int QUO_PROD_W = IDX_W + RECIP_W;

  typedef logic [MAX_ORDER-1:0][DATA_W-1:0] row_t;

  function automatic logic signed [RND_W-1:0] round_sum(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] t;
    t = v + (v[SUM_W-1] ? SUM_W'(RND_NEG) : SUM_W'(RND_POS));
    return RND_W'(t >>> FRAC_W);
  endfunction

  function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
    if (x[SAT_W-1:DATA_W-1] == '0 || x[SAT_W-1:DATA_W-1] == '1) begin
      return x[DATA_W-1:0];
    end
    return x[SAT_W-1] ? SAT_MIN : SAT_MAX;
  endfunction

  logic [ORD_W-1:0]  order;
  logic [DATA_W-1:0] inv_step;
  logic              scale_by_step;
  logic [ORD_W-1:0]  eff_ord;
  logic [ORD_W-1:0]  coef_sel;
  logic              adv;

  logic                  s1_valid;
  elem_t                 s1_elem;
  logic [IDX_W-1:0]      s1_quo;
  logic [QUO_PROD_W-1:0] quo_prod;
  logic [DATA_W-1:0]     rem;
  logic [POS_W-1:0]      pos1;

  row_t             hist_mem [VECTOR_LEN];
  row_t             rd_row;
  row_t             old_row;
  row_t             new_row;
  logic             s2_valid;
  elem_t            s2_elem;
  logic [POS_W-1:0] s2_pos;

  logic             s3_valid;
  logic [IDX_W-1:0] s3_idx;
  logic             s3_last;
  logic [POS_W-1:0] s3_pos;
  row_t             s3_row;
  logic signed [PROD_W-1:0] pa [MAX_ORDER];
  logic signed [PROD_W-1:0] pb [MAX_ORDER];

  logic             s4_valid;
  logic [IDX_W-1:0] s4_idx;
  logic             s4_last;
  logic signed [PROD_W-1:0] s4_pa [MAX_ORDER];
  logic signed [PROD_W-1:0] s4_pb [MAX_ORDER];
  logic signed [SUM_W-1:0]  sd;
  logic signed [SUM_W-1:0]  se;

  logic             s5_valid;
  logic [IDX_W-1:0] s5_idx;
  logic             s5_last;
  logic signed [SUM_W-1:0] s5_sd;
  logic signed [SUM_W-1:0] s5_se;

  logic             s6_valid;
  logic [IDX_W-1:0] s6_idx;
  logic             s6_last;
  logic signed [RND_W-1:0] s6_d;
  logic signed [RND_W-1:0] s6_e;
  logic [2*DATA_W-1:0]     pl;
  logic signed [PH_W-1:0]  ph;

  logic             s7_valid;
  logic [IDX_W-1:0] s7_idx;
  logic             s7_last;
  logic signed [RND_W-1:0] s7_d;
  logic signed [RND_W-1:0] s7_e;
  logic [2*DATA_W-1:0]     s7_pl;
  logic signed [PH_W-1:0]  s7_ph;
  logic signed [SCL_W-1:0] prod;
  logic signed [SCL_W-1:0] prod_rnd;
  logic signed [SAT_W-1:0] scaled;
  logic signed [SAT_W-1:0] deriv_pre;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order         <= 2'd1;
      inv_step      <= 32'd65536;
      scale_by_step <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ORDER:    order         <= cfg_data[ORD_W-1:0];
        REG_INV_STEP: inv_step      <= cfg_data;
        REG_SCALE:    scale_by_step <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (order == 2'd0) begin
      eff_ord = 2'd1;
    end else if (order > ORD_W'(MAX_ORDER)) begin
      eff_ord = ORD_W'(MAX_ORDER);
    end else begin
      eff_ord = order;
    end
    coef_sel = eff_ord - 2'd1;
  end

  assign adv        = !result_valid || !result_stall;
  assign elem_stall = !adv;

  assign quo_prod = QUO_PROD_W'(elem.elem_index) * QUO_PROD_W'(RECIP);
  assign rem      = DATA_W'(s1_elem.elem_index) - DATA_W'(s1_quo) * DATA_W'(VECTOR_LEN);
  assign pos1     = rem[POS_W-1:0];

  // history memory: read on entry to stage 2, write back on exit
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_row <= hist_mem[pos1];
      if (s2_valid) begin
        hist_mem[s2_pos] <= new_row;
      end
    end
  end

  // forward the row written in the previous cycle
  assign old_row = (s3_valid && s3_pos == s2_pos) ? s3_row : rd_row;

  always_comb begin
    new_row[0] = s2_elem.sample;
    for (int k = 1; k < MAX_ORDER; k++) begin
      new_row[k] = s2_elem.init ? s2_elem.sample : old_row[k-1];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_ORDER; k++) begin
      pa[k] = $signed(s3_row[k]) * ALPHA_TAB[coef_sel][k];
      pb[k] = $signed(s3_row[k]) * BETA_TAB[coef_sel][k];
    end
  end

  always_comb begin
    sd = '0;
    se = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      sd = sd + SUM_W'(s4_pa[k]);
      se = se + SUM_W'(s4_pb[k]);
    end
  end

  assign pl = (2*DATA_W)'(s6_d[DATA_W-1:0]) * (2*DATA_W)'(inv_step);
  assign ph = $signed(s6_d[RND_W-1:DATA_W]) * $signed({1'b0, inv_step});

  always_comb begin
    prod      = $signed(SCL_W'(s7_ph) << DATA_W) + $signed(SCL_W'(s7_pl));
    prod_rnd  = prod + (prod[SCL_W-1] ? SCL_W'(RND_NEG) : SCL_W'(RND_POS));
    scaled    = SAT_W'(prod_rnd >>> FRAC_W);
    deriv_pre = scale_by_step ? scaled : SAT_W'(s7_d);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      s4_valid     <= 1'b0;
      s5_valid     <= 1'b0;
      s6_valid     <= 1'b0;
      s7_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= elem_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      s4_valid     <= s3_valid;
      s5_valid     <= s4_valid;
      s6_valid     <= s5_valid;
      s7_valid     <= s6_valid;
      result_valid <= s7_valid;
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_elem <= elem;
      s1_quo  <= IDX_W'(quo_prod >> RECIP_SH);

      s2_elem <= s1_elem;
      s2_pos  <= pos1;

      s3_idx  <= s2_elem.elem_index;
      s3_last <= s2_elem.last_in;
      s3_pos  <= s2_pos;
      s3_row  <= new_row;

      s4_idx  <= s3_idx;
      s4_last <= s3_last;
      s4_pa   <= pa;
      s4_pb   <= pb;

      s5_idx  <= s4_idx;
      s5_last <= s4_last;
      s5_sd   <= sd;
      s5_se   <= se;

      s6_idx  <= s5_idx;
      s6_last <= s5_last;
      s6_d    <= round_sum(s5_sd);
      s6_e    <= round_sum(s5_se);

      s7_idx  <= s6_idx;
      s7_last <= s6_last;
      s7_d    <= s6_d;
      s7_e    <= s6_e;
      s7_pl   <= pl;
      s7_ph   <= ph;

      result.out_index    <= s7_idx;
      result.deriv_term   <= sat32(deriv_pre);
      result.extrapolated <= sat32(SAT_W'(s7_e));
      result.last_out     <= s7_last;
    end
  end

endmodule

// ===== rtl/core/bdf_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the BDF history unit and their bind.
module bdf_checker (
  input logic             clk,
  input logic             rst,
  input logic             elem_stall,
  input logic             result_valid,
  input logic             result_stall,
  input bdf_pkg::result_t result
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  a_stall_follows_output: assert property (@(posedge clk)
    elem_stall == (result_valid && result_stall))
    else $error("element stall does not follow a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !elem_stall)
    else $error("pipeline not empty after reset");

endmodule

bind bdf_history_derivative_extrapolator bdf_checker u_bdf_checker (.*);
